// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked property, disabled while the active-low reset is low.
`define CLL_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Same, but checked during reset as well.
`define CLL_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ----- rtl/clle_pkg.sv -----
// Types and codes of the cursor linked list engine.
// No dependencies.
package clle_pkg;
  localparam logic [2:0] CMD_BEGIN  = 3'd0;
  localparam logic [2:0] CMD_END    = 3'd1;
  localparam logic [2:0] CMD_INSERT = 3'd2;
  localparam logic [2:0] CMD_ERASE  = 3'd3;
  localparam logic [2:0] CMD_NEXT   = 3'd4;
  localparam logic [2:0] CMD_PREV   = 3'd5;
  localparam logic [2:0] CMD_FIND   = 3'd6;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_MATCH    = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  // divider handshake
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } clle_div_req_t;

  typedef struct packed {
    logic done;
    logic zero_rem;
  } clle_div_rsp_t;
endpackage

// ----- rtl/clle_divider.sv -----
// Restoring bit-serial remainder unit, one quotient bit per cycle.
// Depends on clle_pkg.
module clle_divider
  import clle_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  clle_div_req_t req,
  output clle_div_rsp_t rsp
);
  logic [31:0] num_r, num_nxt;
  logic [31:0] den_r, den_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] shifted;
  logic [32:0] diff;

  assign shifted = {rem_r[31:0], num_r[31]};
  assign diff    = shifted - {1'b0, den_r};

  always_comb begin
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      num_nxt  = req.dividend;
      den_nxt  = req.divisor;
      rem_nxt  = '0;
      cnt_nxt  = 6'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[30:0], 1'b0};
      rem_nxt = diff[32] ? shifted : diff;
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.zero_rem = (rem_r == '0);
endmodule

// ----- rtl/cursor_linked_list_engine_unit.sv -----
// Cursor linked list engine: doubly linked list in a slot pool with a free stack.
// A non-query command passes S_RD and S_EXEC, an executed insert or erase also S_WR2; the
// result waits in a pending register, and the next item is taken once that register is free.
// Query: S_FRD reads each element, S_FDIV skips a zero and starts the divider on any other,
// and a match waits in S_OUT. One command at a time, paced by the walk and 32-step divider.
// Reset: synchronous active low; the free stack is refilled in S_CLEAR, no item taken there.
module cursor_linked_list_engine_unit
  import clle_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic signed [31:0] in_operand_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [5:0]  out_match_index,
  output logic        out_last_result
);
  localparam int SW = $clog2(CAPACITY);
  localparam int LW = SW + 1;
  localparam logic [LW-1:0] END_MARK = LW'(CAPACITY);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_EXEC  = 4'd3;
  localparam logic [3:0] S_WR2   = 4'd4;
  localparam logic [3:0] S_FRD   = 4'd5;
  localparam logic [3:0] S_FDIV  = 4'd6;
  localparam logic [3:0] S_FWAIT = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;
  localparam logic [3:0] S_FEND  = 4'd9;

  // node memory: value, next, prev
  logic [31:0]   val_mem  [CAPACITY];
  logic [LW-1:0] next_mem [CAPACITY];
  logic [LW-1:0] prev_mem [CAPACITY];
  logic [SW-1:0] free_mem [CAPACITY];

  logic [3:0]    state_r, state_nxt;
  logic [2:0]    cmd_r;
  logic [31:0]   opv_r;
  logic [LW-1:0] first_r, last_r, cur_r, count_r;
  logic [SW-1:0] clr_r;
  logic [LW-1:0] walk_r, pos_r;
  logic          found_r;
  logic [5:0]    hold_idx_r;
  logic [LW-1:0] slot_r, before_r;

  // memory port signals
  logic          rd_en;
  logic [SW-1:0] rd_addr;
  logic [31:0]   rd_val_r;
  logic [LW-1:0] rd_next_r, rd_prev_r;
  logic [SW-1:0] fr_addr;
  logic [SW-1:0] fr_data_r;
  logic          fr_we;
  logic [SW-1:0] fr_waddr, fr_wdata;

  // output and pending result registers
  logic          ov_r;
  logic [2:0]    ost_r;
  logic [5:0]    oidx_r;
  logic          olast_r;
  logic          pend_r;
  logic [2:0]    pst_r;
  logic [5:0]    pidx_r;
  logic          plast_r;

  clle_div_req_t dreq;
  clle_div_rsp_t drsp;
  clle_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  function automatic logic [31:0] mag(input logic [31:0] v);
    mag = v[31] ? (32'd0 - v) : v;
  endfunction

  function automatic logic live(input logic [LW-1:0] s);
    live = (s < END_MARK);
  endfunction

  assign in_stall = (state_r != S_IDLE) || pend_r;
  assign out_valid       = ov_r;
  assign out_status      = ost_r;
  assign out_match_index = oidx_r;
  assign out_last_result = olast_r;

  // move a pending result into the output register when it is free
  logic emit_free;
  assign emit_free = !ov_r || !out_stall;

  logic          push;
  logic [2:0]    push_st;
  logic [5:0]    push_idx;
  logic          push_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r   <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      if (emit_free) begin
        ov_r <= pend_r;
        if (pend_r) begin
          ost_r   <= pst_r;
          oidx_r  <= pidx_r;
          olast_r <= plast_r;
        end
      end
      if (push) begin
        pend_r  <= 1'b1;
        pst_r   <= push_st;
        pidx_r  <= push_idx;
        plast_r <= push_last;
      end else if (emit_free) begin
        pend_r <= 1'b0;
      end
    end
  end

  // memory writes and registered reads
  logic          nw_we_val, nw_we_next, nw_we_prev;
  logic [SW-1:0] nw_a_val, nw_a_next, nw_a_prev;
  logic [31:0]   nw_d_val;
  logic [LW-1:0] nw_d_next, nw_d_prev;

  always_ff @(posedge clk) begin
    if (nw_we_val)  val_mem[nw_a_val]   <= nw_d_val;
    if (nw_we_next) next_mem[nw_a_next] <= nw_d_next;
    if (nw_we_prev) prev_mem[nw_a_prev] <= nw_d_prev;
    if (fr_we)      free_mem[fr_waddr]  <= fr_wdata;
    if (rd_en) begin
      rd_val_r  <= val_mem[rd_addr];
      rd_next_r <= next_mem[rd_addr];
      rd_prev_r <= prev_mem[rd_addr];
    end
    fr_data_r <= free_mem[fr_addr];
  end

  logic [LW-1:0] fidx;
  assign fidx = END_MARK - 1'b1 - count_r;

  logic can_emit_find;
  assign can_emit_find = !pend_r;

  always_comb begin
    state_nxt  = state_r;
    rd_en      = 1'b0;
    rd_addr    = cur_r[SW-1:0];
    fr_addr    = fidx[SW-1:0];
    fr_we      = 1'b0;
    fr_waddr   = clr_r;
    fr_wdata   = clr_r;
    nw_we_val  = 1'b0; nw_a_val  = slot_r[SW-1:0]; nw_d_val  = opv_r;
    nw_we_next = 1'b0; nw_a_next = slot_r[SW-1:0]; nw_d_next = cur_r;
    nw_we_prev = 1'b0; nw_a_prev = slot_r[SW-1:0]; nw_d_prev = before_r;
    push = 1'b0; push_st = ST_OK; push_idx = '0; push_last = 1'b1;
    dreq.start = 1'b0;
    dreq.dividend = mag(opv_r);
    dreq.divisor  = mag(rd_val_r);
    unique case (state_r)
      S_CLEAR: begin
        fr_we = 1'b1;
        if (clr_r == SW'(CAPACITY - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && !pend_r) begin
          if (in_cmd == CMD_FIND) begin
            state_nxt = S_FRD;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        rd_en = live(cur_r);
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        push = 1'b1;
        case (cmd_r)
          CMD_INSERT: begin
            if (count_r >= END_MARK) push_st = ST_FULL;
            else begin
              push = 1'b0;
              state_nxt = S_WR2;
              nw_we_val = 1'b1;
              nw_we_next = 1'b1;
              nw_we_prev = 1'b1;
              nw_a_val = fr_data_r; nw_a_next = fr_data_r; nw_a_prev = fr_data_r;
              nw_d_prev = live(cur_r) ? rd_prev_r : last_r;
            end
          end
          CMD_ERASE: begin
            if (count_r == '0) push_st = ST_EMPTY;
            else if (live(cur_r)) begin
              push = 1'b0;
              state_nxt = S_WR2;
              nw_we_next = live(rd_prev_r);
              nw_a_next  = rd_prev_r[SW-1:0];
              nw_d_next  = rd_next_r;
              nw_we_prev = live(rd_next_r);
              nw_a_prev  = rd_next_r[SW-1:0];
              nw_d_prev  = rd_prev_r;
            end
          end
          default: ;
        endcase
      end
      S_WR2: begin
        state_nxt = S_IDLE;
        push = 1'b1;
        if (cmd_r == CMD_INSERT) begin
          nw_we_next = live(before_r);
          nw_a_next  = before_r[SW-1:0];
          nw_d_next  = slot_r;
          nw_we_prev = live(cur_r);
          nw_a_prev  = cur_r[SW-1:0];
          nw_d_prev  = slot_r;
        end else begin
          // count already dropped, so fidx is the slot just above the stack top
          fr_we    = 1'b1;
          fr_waddr = fidx[SW-1:0];
          fr_wdata = cur_r[SW-1:0];
        end
      end
      S_FRD: begin
        if (live(walk_r) && pos_r < END_MARK) begin
          rd_en = 1'b1;
          rd_addr = walk_r[SW-1:0];
          state_nxt = S_FDIV;
        end else state_nxt = S_FEND;
      end
      S_FDIV: begin
        if (mag(rd_val_r) == '0) state_nxt = S_FRD;
        else begin
          dreq.start = 1'b1;
          state_nxt = S_FWAIT;
        end
      end
      S_FWAIT: begin
        if (drsp.done) begin
          state_nxt = drsp.zero_rem ? S_OUT : S_FRD;
        end
      end
      S_OUT: begin
        // a match is held until the next match or the end of the walk
        if (can_emit_find) state_nxt = S_FRD;
      end
      S_FEND: begin
        if (!pend_r) begin
          push = 1'b1;
          state_nxt = S_IDLE;
          if (found_r) begin
            push_st = ST_MATCH; push_idx = hold_idx_r; push_last = 1'b1;
          end else push_st = ST_NOTFOUND;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (state_r == S_OUT && can_emit_find && found_r) begin
      push = 1'b1; push_st = ST_MATCH; push_idx = hold_idx_r; push_last = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      first_r <= END_MARK;
      last_r  <= END_MARK;
      cur_r   <= END_MARK;
      count_r <= '0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + 1'b1;
      if (state_r == S_IDLE && in_valid && !pend_r) begin
        cmd_r   <= in_cmd;
        opv_r   <= in_operand_value;
        walk_r  <= first_r;
        pos_r   <= '0;
        found_r <= 1'b0;
        case (in_cmd)
          CMD_BEGIN: cur_r <= first_r;
          CMD_END:   cur_r <= END_MARK;
          default: ;
        endcase
      end
      if (state_r == S_EXEC) begin
        case (cmd_r)
          CMD_NEXT: if (live(cur_r)) cur_r <= rd_next_r;
          CMD_PREV: if (cur_r != first_r) cur_r <= live(cur_r) ? rd_prev_r : last_r;
          CMD_INSERT: if (count_r < END_MARK) begin
            slot_r   <= {1'b0, fr_data_r};
            before_r <= live(cur_r) ? rd_prev_r : last_r;
          end
          CMD_ERASE: if (count_r != '0 && live(cur_r)) begin
            if (!live(rd_prev_r)) first_r <= rd_next_r;
            if (!live(rd_next_r)) last_r  <= rd_prev_r;
            count_r <= count_r - 1'b1;
            before_r <= live(rd_prev_r) ? first_r : rd_next_r;
          end
          default: ;
        endcase
      end
      if (state_r == S_WR2) begin
        if (cmd_r == CMD_INSERT) begin
          if (!live(before_r)) first_r <= slot_r;
          if (!live(cur_r))    last_r  <= slot_r;
          count_r <= count_r + 1'b1;
        end else begin
          cur_r <= before_r;
        end
      end
      if (state_r == S_FDIV) begin
        walk_r <= rd_next_r;
        pos_r  <= pos_r + 1'b1;
      end
      if (state_r == S_OUT && can_emit_find) begin
        found_r    <= 1'b1;
        hold_idx_r <= 6'(pos_r - 1'b1);
      end
    end
  end
endmodule

// ----- rtl/clle_checker.sv -----
// Port-level checker for the cursor linked list engine, bound to the engine module.
// Depends on clle_pkg and assert_macros.svh.
`include "assert_macros.svh"
module clle_checker
  import clle_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_status,
  input logic       out_last_result
);
  logic out_held;
  logic out_inner;
  assign out_held  = out_valid && out_stall;
  assign out_inner = out_valid && !out_last_result;

  `CLL_ASSERT(a_out_hold, clk, rst_n, out_held |=> out_valid && $stable(out_status), "result changed")
  `CLL_ASSERT(a_inner_match, clk, rst_n, out_inner |-> out_status == ST_MATCH, "inner result not a match")
  `CLL_ASSERT(a_status_range, clk, rst_n, out_valid |-> out_status <= ST_FULL, "bad status code")
  `CLL_ASSERT_ALWAYS(a_reset_stall, clk, !rst_n |=> in_stall, "item taken right after reset")
endmodule

bind cursor_linked_list_engine_unit clle_checker u_clle_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
  .out_last_result(out_last_result)
);

// ----- sim/tb_cursor_linked_list_engine_unit.sv -----
// Testbench for cursor_linked_list_engine_unit: a list model in the bench predicts
// every result; a checker compares each result item with the oldest prediction.
// Depends on clle_pkg and the engine RTL.
module tb_cursor_linked_list_engine_unit;
  import clle_pkg::*;

  localparam int CAP = 64;
  localparam int LIMIT_NS = 40_000_000;
  localparam logic [2:0] CMD_UNUSED = 3'd7;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] match_index;
    logic       last_result;
  } list_answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_cmd = CMD_BEGIN;
  logic signed [31:0] in_operand_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_status;
  logic [5:0] out_match_index;
  logic out_last_result;

  cursor_linked_list_engine_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_cmd(in_cmd), .in_operand_value(in_operand_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_match_index(out_match_index),
    .out_last_result(out_last_result)
  );

  // list shadow: element values in list order, cursor as a position (size = end)
  logic signed [31:0] shadow_list[$];
  int cursor_pos;
  list_answer_t pending_answers[$];
  int errors = 0;
  bit sender_idle_on = 1'b1;
  bit receiver_idle_on = 1'b1;
  bit hold_receiver = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #LIMIT_NS;
    $display("cursor_linked_list_engine_unit regression: fail");
    $finish;
  end

  function automatic logic [31:0] abs_value(logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  function automatic void push_answer(logic [2:0] st, logic [5:0] idx, logic lst);
    list_answer_t a;
    a.status = st;
    a.match_index = idx;
    a.last_result = lst;
    pending_answers.push_back(a);
  endfunction

  function automatic void predict_command(logic [2:0] cmd, logic [31:0] val);
    logic [2:0] st;
    logic [31:0] mv, dm;
    int hits;
    st = ST_OK;
    hits = 0;
    case (cmd)
      CMD_BEGIN: cursor_pos = 0;
      CMD_END: cursor_pos = shadow_list.size();
      CMD_INSERT: begin
        if (shadow_list.size() >= CAP) st = ST_FULL;
        else begin
          shadow_list.insert(cursor_pos, val);
          cursor_pos++;
        end
      end
      CMD_ERASE: begin
        if (shadow_list.size() == 0) st = ST_EMPTY;
        else if (cursor_pos < shadow_list.size()) begin
          shadow_list.delete(cursor_pos);
          cursor_pos = 0;
        end
      end
      CMD_NEXT: if (cursor_pos < shadow_list.size()) cursor_pos++;
      CMD_PREV: if (cursor_pos > 0) cursor_pos--;
      CMD_FIND: begin
        mv = abs_value(val);
        foreach (shadow_list[i]) begin
          dm = abs_value(shadow_list[i]);
          if (dm != 0 && mv % dm == 0) begin
            if (hits > 0) pending_answers[pending_answers.size() - 1].last_result = 1'b0;
            push_answer(ST_MATCH, i[5:0], 1'b1);
            hits++;
          end
        end
        if (hits == 0) push_answer(ST_NOTFOUND, 6'd0, 1'b1);
        return;
      end
      default: ;
    endcase
    push_answer(st, 6'd0, 1'b1);
  endfunction

  // check each result item at the edge where it is taken
  always @(posedge clk) begin
    list_answer_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result status=%0d index=%0d last=%0d",
                 $time, out_status, out_match_index, out_last_result);
        errors++;
      end else begin
        want = pending_answers.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          errors++;
        end
        if (out_match_index !== want.match_index) begin
          $display("%0t: match_index expected %0d actual %0d",
                   $time, want.match_index, out_match_index);
          errors++;
        end
        if (out_last_result !== want.last_result) begin
          $display("%0t: last_result expected %0d actual %0d",
                   $time, want.last_result, out_last_result);
          errors++;
        end
      end
    end
  end

  // receiver stall: random bursts, or a long hold-off when asked
  initial begin
    int burst;
    forever begin
      @(posedge clk);
      if (hold_receiver) begin
        out_stall <= 1'b1;
      end else if (receiver_idle_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 16);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_item(logic [2:0] cmd, logic signed [31:0] val);
    int gap;
    if (sender_idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_operand_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_command(cmd, val);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic signed [31:0] random_value();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7fff_ffff;
      1: return $signed(32'($urandom_range(0, 24))) - 12;
      2: return $signed(32'($urandom_range(1, 200)));
      default: return $signed($urandom());
    endcase
  endfunction

  task automatic test_directed();
    send_item(CMD_ERASE, 0);      // erase on empty
    send_item(CMD_BEGIN, 0);      // begin on empty
    send_item(CMD_PREV, 0);       // prev on empty
    send_item(CMD_NEXT, 0);       // next at end
    send_item(CMD_FIND, 12);      // query on empty
    send_item(CMD_INSERT, 0);     // zero never matches
    send_item(CMD_INSERT, -1);
    send_item(CMD_INSERT, 32'sh8000_0000);
    send_item(CMD_INSERT, 32'sh7fff_ffff);
    send_item(CMD_INSERT, 3);
    send_item(CMD_FIND, 32'sh8000_0000);  // -1 divides the most negative value
    send_item(CMD_FIND, -6);
    send_item(CMD_FIND, 7);
    send_item(CMD_PREV, 0);       // prev at end goes to last
    send_item(CMD_ERASE, 0);
    send_item(CMD_END, 0);
    send_item(CMD_ERASE, 0);      // erase at end of non-empty list
    send_item(CMD_NEXT, 0);
    send_item(CMD_PREV, 0);       // prev at end again goes to last
    send_item(CMD_UNUSED, 32'h5555_aaaa);  // undefined command
    send_item(CMD_FIND, 0);
    drain();
  endtask

  // fill the pool to capacity, try to insert past it, then query a full list so indices reach 63
  task automatic test_full_pool();
    while (shadow_list.size() < CAP) send_item(CMD_INSERT, $urandom_range(0, 1) ? 1 : -2);
    send_item(CMD_INSERT, 5);     // full
    send_item(CMD_BEGIN, 0);
    send_item(CMD_INSERT, 9);     // full at first
    send_item(CMD_FIND, 4);
    send_item(CMD_END, 0);
    send_item(CMD_PREV, 0);
    send_item(CMD_INSERT, 1);     // full, element stays
    while (shadow_list.size() > 0) send_item(CMD_ERASE, 0);
    send_item(CMD_ERASE, 0);
    drain();
  endtask

  // stall the receiver for a long stretch so the block backs up into its input
  task automatic test_backpressure();
    hold_receiver = 1'b1;
    fork
      begin
        repeat (12) send_item($urandom_range(0, 1) ? CMD_INSERT : CMD_FIND, random_value());
      end
      begin
        repeat (400) @(posedge clk);
        hold_receiver = 1'b0;
      end
    join
    drain();
  endtask

  task automatic test_random(int n, bit quiet);
    int pick;
    logic [2:0] cmd;
    sender_idle_on = !quiet;
    receiver_idle_on = !quiet;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) cmd = CMD_INSERT;
      else if (pick < 45) cmd = CMD_FIND;
      else if (pick < 58) cmd = CMD_ERASE;
      else if (pick < 70) cmd = CMD_NEXT;
      else if (pick < 82) cmd = CMD_PREV;
      else if (pick < 90) cmd = CMD_BEGIN;
      else if (pick < 98) cmd = CMD_END;
      else cmd = CMD_UNUSED;
      // keep lists short so queries stay quick
      if (cmd == CMD_INSERT && shadow_list.size() > 20) cmd = CMD_ERASE;
      send_item(cmd, random_value());
    end
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    cursor_pos = 0;
    test_directed();
    test_full_pool();
    test_backpressure();
    test_random(50, 1'b0);
    test_random(15, 1'b1);
    if (errors == 0) begin
      $display("cursor_linked_list_engine_unit regression: pass");
    end else begin
      $display("cursor_linked_list_engine_unit regression: fail");
    end
    $finish;
  end
endmodule
